// File: rtl/i2c_master_register_access_assert.svh
// assertion shorthands for the i2c register access block
// both expect clk and rst in scope
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH

// condition and consequence on the same edge
`define I2CMRA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequence on the next edge
`define I2CMRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/i2cmra_pkg.sv
`default_nettype none
package i2cmra_pkg;

  localparam int BUF_DEPTH_DEF = 16;
  localparam logic [7:0] GAP_RESET = 8'd4;

  // command codes carried by func
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_QUEUE = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // transaction outcome codes
  localparam logic [1:0] OUT_OK      = 2'd0;
  localparam logic [1:0] OUT_NACK    = 2'd1;
  localparam logic [1:0] OUT_BAD_LEN = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] device_addr;
    logic [7:0] register_addr;
    logic [4:0] byte_count;
    logic [7:0] payload_byte;
    logic       sda_sample;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_level;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       busy_res;
    logic       finished;
    logic [1:0] outcome;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/i2cmra_payload_mem.sv
`default_nettype none
module i2cmra_payload_mem #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/i2cmra_seq.sv
`default_nettype none
`include "i2c_master_register_access_assert.svh"
module i2cmra_seq #(
  parameter int BUF_DEPTH = i2cmra_pkg::BUF_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire i2cmra_pkg::cmd_t   cmd,
  input  wire logic [7:0]         gap_ticks,
  output i2cmra_pkg::res_t        res
);
  import i2cmra_pkg::*;

  localparam int PW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int FW = $clog2(BUF_DEPTH + 1);
  localparam int CW = (FW > 5) ? FW : 5;
  localparam int SW = CW + 1;
  localparam logic [PW-1:0] PTR_LAST = PW'(BUF_DEPTH - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(BUF_DEPTH);

  typedef enum logic [4:0] {
    P_IDLE, P_START_SDA, P_START_SCL,
    P_TX_SET, P_TX_HI, P_TX_LO,
    P_ACK_REL, P_ACK_HI, P_ACK_SAMPLE, P_ACK_LEVEL, P_ACK_DRIVE, P_ACK_LO,
    P_RS_SCL, P_RS_SDA,
    P_RX_REL, P_RX_HI, P_RX_SAMPLE, P_RX_LO,
    P_RX_ACKLEVEL, P_RX_ACKDRIVE, P_RX_ACKHI, P_RX_ACKLO,
    P_GAP, P_END_SDA0, P_END_SCL, P_END_SDA1
  } phase_t;

  typedef enum logic [1:0] {
    STG_DEV, STG_REG, STG_ADDR2, STG_RX
  } stage_t;

  phase_t        phase, phase_next;
  stage_t        stage, stage_next;
  logic [3:0]    bit_count, bit_count_next;
  logic [4:0]    bytes_left, bytes_left_next;
  logic [7:0]    shifter, shifter_next;
  logic [FW-1:0] fill, fill_next;
  logic [PW-1:0] rd_ptr, rd_ptr_next;
  logic          is_read, is_read_next;
  logic [7:0]    gap_count, gap_count_next;
  logic [15:0]   saved_addr, saved_addr_next;
  logic [1:0]    pending, pending_next;
  logic          scl, scl_next;
  logic          drive, drive_next;
  logic          level, level_next;

  logic          mem_we;
  logic [7:0]    mem_rdata;
  logic          do_end_ack;
  logic          do_after;
  logic          rd_cmd;
  logic          bad_len;
  logic          fin;
  logic [1:0]    code;
  logic          rvalid;
  logic          rlast;
  logic [7:0]    rbyte;

  // payload queue; read port always follows rd_ptr so the next byte is ready
  i2cmra_payload_mem #(
    .DEPTH(BUF_DEPTH),
    .AW   (PW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(fill[PW-1:0]),
    .wdata(cmd.payload_byte),
    .raddr(rd_ptr),
    .rdata(mem_rdata)
  );

  assign rd_cmd  = (cmd.func == FUNC_READ);
  assign bad_len = rd_cmd ? (cmd.byte_count == 5'd0)
                          : (CW'(cmd.byte_count) > CW'(fill));
  assign mem_we  = step && (phase == P_IDLE) && (cmd.func == FUNC_QUEUE)
                   && (fill < FILL_FULL);

  always_comb begin
    phase_next      = phase;
    stage_next      = stage;
    bit_count_next  = bit_count;
    bytes_left_next = bytes_left;
    shifter_next    = shifter;
    fill_next       = fill;
    rd_ptr_next     = rd_ptr;
    is_read_next    = is_read;
    gap_count_next  = gap_count;
    saved_addr_next = saved_addr;
    pending_next    = pending;
    scl_next        = scl;
    drive_next      = drive;
    level_next      = level;
    do_end_ack      = 1'b0;
    do_after        = 1'b0;
    fin             = 1'b0;
    code            = OUT_OK;
    rvalid          = 1'b0;
    rlast           = 1'b0;
    rbyte           = 8'd0;

    unique case (phase)
      P_IDLE: begin
        if (cmd.func == FUNC_QUEUE) begin
          if (fill < FILL_FULL) begin
            fill_next = fill + 1'b1;
          end
        end else if (cmd.func == FUNC_WRITE || cmd.func == FUNC_READ) begin
          if (bad_len) begin
            fin  = 1'b1;
            code = OUT_BAD_LEN;
          end else begin
            is_read_next    = rd_cmd;
            bytes_left_next = cmd.byte_count;
            rd_ptr_next     = '0;
            saved_addr_next = {cmd.device_addr, cmd.register_addr};
            stage_next      = STG_DEV;
            drive_next      = 1'b1;
            level_next      = 1'b0;
            phase_next      = P_START_SCL;
          end
        end
      end
      P_START_SDA: begin
        drive_next = 1'b1;
        level_next = 1'b0;
        phase_next = P_START_SCL;
      end
      P_START_SCL: begin
        scl_next       = 1'b0;
        shifter_next   = (stage == STG_DEV) ? saved_addr[15:8]
                                            : (saved_addr[15:8] | 8'h01);
        bit_count_next = 4'd0;
        phase_next     = P_TX_SET;
      end
      P_TX_SET: begin
        drive_next = 1'b1;
        level_next = shifter[7];
        phase_next = P_TX_HI;
      end
      P_TX_HI: begin
        scl_next   = 1'b1;
        phase_next = P_TX_LO;
      end
      P_TX_LO: begin
        scl_next       = 1'b0;
        shifter_next   = {shifter[6:0], 1'b0};
        bit_count_next = bit_count + 1'b1;
        phase_next     = (bit_count_next >= 4'd8) ? P_ACK_REL : P_TX_SET;
      end
      P_ACK_REL: begin
        drive_next = 1'b0;
        phase_next = P_ACK_HI;
      end
      P_ACK_HI: begin
        scl_next   = 1'b1;
        phase_next = P_ACK_SAMPLE;
      end
      P_ACK_SAMPLE: begin
        shifter_next = {7'd0, cmd.sda_sample};
        phase_next   = P_ACK_LEVEL;
      end
      P_ACK_LEVEL: begin
        level_next = shifter[0];
        phase_next = P_ACK_DRIVE;
      end
      P_ACK_DRIVE: begin
        drive_next = 1'b1;
        phase_next = P_ACK_LO;
      end
      P_ACK_LO: begin
        scl_next   = 1'b0;
        do_end_ack = 1'b1;
      end
      P_RS_SCL: begin
        scl_next   = 1'b1;
        phase_next = P_RS_SDA;
      end
      P_RS_SDA: begin
        drive_next = 1'b1;
        level_next = 1'b1;
        stage_next = STG_ADDR2;
        phase_next = P_START_SDA;
      end
      P_RX_REL: begin
        drive_next = 1'b0;
        phase_next = P_RX_HI;
      end
      P_RX_HI: begin
        scl_next   = 1'b1;
        phase_next = P_RX_SAMPLE;
      end
      P_RX_SAMPLE: begin
        shifter_next = {shifter[6:0], cmd.sda_sample};
        phase_next   = P_RX_LO;
      end
      P_RX_LO: begin
        scl_next       = 1'b0;
        bit_count_next = bit_count + 1'b1;
        phase_next     = (bit_count_next >= 4'd8) ? P_RX_ACKLEVEL : P_RX_HI;
      end
      P_RX_ACKLEVEL: begin
        level_next = (bytes_left <= 5'd1);
        phase_next = P_RX_ACKDRIVE;
      end
      P_RX_ACKDRIVE: begin
        drive_next = 1'b1;
        phase_next = P_RX_ACKHI;
      end
      P_RX_ACKHI: begin
        scl_next   = 1'b1;
        phase_next = P_RX_ACKLO;
      end
      P_RX_ACKLO: begin
        scl_next   = 1'b0;
        rvalid     = 1'b1;
        rbyte      = shifter;
        rlast      = (bytes_left <= 5'd1);
        if (bytes_left != 5'd0) begin
          bytes_left_next = bytes_left - 1'b1;
        end
        do_end_ack = 1'b1;
      end
      P_GAP: begin
        if (gap_count != 8'd0) begin
          gap_count_next = gap_count - 1'b1;
        end
        do_after = (gap_count_next == 8'd0);
      end
      P_END_SDA0: begin
        drive_next = 1'b1;
        level_next = 1'b0;
        phase_next = P_END_SCL;
      end
      P_END_SCL: begin
        scl_next   = 1'b1;
        phase_next = P_END_SDA1;
      end
      P_END_SDA1: begin
        drive_next = 1'b1;
        level_next = 1'b1;
        fin        = 1'b1;
        code       = pending;
        if (!is_read) begin
          fill_next   = '0;
          rd_ptr_next = '0;
        end
        phase_next = P_IDLE;
      end
      default: begin
        phase_next = P_IDLE;
      end
    endcase

    // acknowledge phase done: idle gap or straight on
    if (do_end_ack) begin
      if (gap_ticks == 8'd0) begin
        do_after = 1'b1;
      end else begin
        gap_count_next = gap_ticks;
        phase_next     = P_GAP;
      end
    end

    // choose what follows a finished byte
    if (do_after) begin
      if (stage == STG_RX) begin
        if (bytes_left_next != 5'd0) begin
          stage_next     = STG_RX;
          bit_count_next = 4'd0;
          shifter_next   = 8'd0;
          phase_next     = P_RX_REL;
        end else begin
          pending_next = OUT_OK;
          phase_next   = P_END_SDA0;
        end
      end else if (shifter_next[0]) begin
        pending_next = OUT_NACK;
        phase_next   = P_END_SDA0;
      end else if (stage == STG_DEV) begin
        stage_next     = STG_REG;
        shifter_next   = saved_addr[7:0];
        bit_count_next = 4'd0;
        phase_next     = P_TX_SET;
      end else if (is_read) begin
        if (stage == STG_REG) begin
          phase_next = P_RS_SCL;
        end else begin
          stage_next     = STG_RX;
          bit_count_next = 4'd0;
          shifter_next   = 8'd0;
          phase_next     = P_RX_REL;
        end
      end else if (bytes_left_next != 5'd0) begin
        shifter_next    = mem_rdata;
        bit_count_next  = 4'd0;
        phase_next      = P_TX_SET;
        rd_ptr_next     = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
        bytes_left_next = bytes_left_next - 1'b1;
        stage_next      = STG_ADDR2;
      end else begin
        pending_next = OUT_OK;
        phase_next   = P_END_SCL;
      end
    end

    res.scl_level  = scl_next;
    res.sda_drive  = drive_next;
    res.sda_level  = drive_next & level_next;
    res.read_byte  = rbyte;
    res.read_valid = rvalid;
    res.read_last  = rlast;
    res.busy_res   = (phase_next != P_IDLE);
    res.finished   = fin;
    res.outcome    = code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= P_IDLE;
      stage      <= STG_DEV;
      bit_count  <= 4'd0;
      bytes_left <= 5'd0;
      shifter    <= 8'd0;
      fill       <= '0;
      rd_ptr     <= '0;
      is_read    <= 1'b0;
      gap_count  <= 8'd0;
      saved_addr <= 16'd0;
      pending    <= OUT_OK;
      scl        <= 1'b1;
      drive      <= 1'b1;
      level      <= 1'b1;
    end else if (step) begin
      phase      <= phase_next;
      stage      <= stage_next;
      bit_count  <= bit_count_next;
      bytes_left <= bytes_left_next;
      shifter    <= shifter_next;
      fill       <= fill_next;
      rd_ptr     <= rd_ptr_next;
      is_read    <= is_read_next;
      gap_count  <= gap_count_next;
      saved_addr <= saved_addr_next;
      pending    <= pending_next;
      scl        <= scl_next;
      drive      <= drive_next;
      level      <= level_next;
    end
  end

  // queue writes only land in a free slot
  `I2CMRA_ASSERT_NOW(a_queue_slot_free, mem_we, fill < FILL_FULL, "queue write with store full")
  // a finished write leaves the queue empty
  `I2CMRA_ASSERT_NEXT(a_write_end_empties, step && phase == P_END_SDA1 && !is_read, fill == '0 && rd_ptr == '0, "queue not emptied after write")
  // a write in flight never reads past what was queued
  `I2CMRA_ASSERT_NOW(a_write_within_fill, phase != P_IDLE && !is_read, (SW'(rd_ptr) + SW'(bytes_left)) <= SW'(fill), "write runs beyond queued bytes")

endmodule
`default_nettype wire

// File: rtl/i2c_master_register_access.sv
`default_nettype none
// i2c master for register writes and reads, one pin action per input beat.
// each beat on the slave side is one tick: it carries a command in tuser
// (tick, queue a payload byte, start a write, start a read) plus the sda
// level seen on that tick, and produces exactly one beat on the master side
// with the scl/sda pin state after the tick's action, any received byte and
// the transaction status. a write sends start, the device address byte, the
// register byte and the queued payload bytes msb first, then stop; a read
// sends the two address bytes, stop, a repeated start and the device address
// with bit 0 set, then clocks in byte_count bytes (ack on each, nack on the
// last). a slave nack ends the transfer with outcome 1; a zero read length or
// a write longer than the queue ends at once with outcome 2. commands other
// than tick are ignored while busy. rate: one beat per clock cycle in steady
// state while the result side takes beats; each tick is one step of the
// sequencer, and the payload store is read ahead of use so it never stalls.
// a registered output stage holds the result beat, so a new beat is taken
// whenever that stage is empty or being drained in the same cycle. there is
// no clearing pass after reset: the payload store is only read at entries
// filled since the last write finished. gap_ticks may only be written while
// no transaction is running.
module i2c_master_register_access #(
  parameter int BUF_DEPTH = i2cmra_pkg::BUF_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: gap_ticks
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  // tick beats in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // device_addr[7:0], register_addr[15:8], byte_count[20:16],
  // payload_byte[28:21], sda_sample[29], zero[31:30]
  input  wire logic [31:0] s_tdata,
  // func[1:0]
  input  wire logic [1:0]  s_tuser,
  // result beats out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // scl_level[0], sda_drive[1], sda_level[2], read_byte[10:3],
  // read_valid[11], busy_res[12], finished[13], outcome[15:14]
  output logic [15:0]      m_tdata,
  // read_last
  output logic             m_tlast
);
  import i2cmra_pkg::*;

  logic [7:0] gap_ticks;
  logic       step;
  cmd_t       cmd;
  res_t       res;
  res_t       res_q;

  // gap register, to be written only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks <= GAP_RESET;
    end else if (cfg_we) begin
      gap_ticks <= cfg_wdata;
    end
  end

  // output stage empty or draining this cycle: take the next tick
  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  // unpack the tick beat
  always_comb begin
    cmd.func          = s_tuser;
    cmd.device_addr   = s_tdata[7:0];
    cmd.register_addr = s_tdata[15:8];
    cmd.byte_count    = s_tdata[20:16];
    cmd.payload_byte  = s_tdata[28:21];
    cmd.sda_sample    = s_tdata[29];
  end

  i2cmra_seq #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .cmd      (cmd),
    .gap_ticks(gap_ticks),
    .res      (res)
  );

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_tdata = {res_q.outcome, res_q.finished, res_q.busy_res, res_q.read_valid,
                    res_q.read_byte, res_q.sda_level, res_q.sda_drive, res_q.scl_level};
  assign m_tlast = res_q.read_last;

endmodule
`default_nettype wire

// File: tb/tb_i2c_master_register_access.sv
`timescale 1ns / 1ps

module tb_i2c_master_register_access;
  import i2cmra_pkg::*;

  localparam int QUEUE_DEPTH = BUF_DEPTH_DEF;

  // sequencer steps of the i2c master, one pin action per tick
  typedef enum int {
    PH_IDLE, PH_START_SDA, PH_START_SCL,
    PH_TX_SET, PH_TX_HI, PH_TX_LO,
    PH_ACK_REL, PH_ACK_HI, PH_ACK_SAMPLE, PH_ACK_LEVEL, PH_ACK_DRIVE, PH_ACK_LO,
    PH_RS_SCL, PH_RS_SDA,
    PH_RX_REL, PH_RX_HI, PH_RX_SAMPLE, PH_RX_LO,
    PH_RX_ACKLEVEL, PH_RX_ACKDRIVE, PH_RX_ACKHI, PH_RX_ACKLO,
    PH_GAP, PH_END_SDA0, PH_END_SCL, PH_END_SDA1
  } bus_phase_t;

  // pin-level model of the master plus the queue of expected result beats
  class i2c_pin_scoreboard;
    logic [7:0] gap_ticks;
    bus_phase_t phase;
    int unsigned bit_cnt;
    int unsigned bytes_left;
    logic [7:0] shifter;
    logic [7:0] payload_mem [QUEUE_DEPTH];
    int unsigned fill;
    int unsigned rd_ptr;
    bit is_read;
    logic [7:0] gap_cnt;
    logic [15:0] addr_pair;
    int unsigned stage;   // 0 device addr, 1 register, 2 payload or read addr, 3 reading
    logic [1:0] pending;
    bit scl, drv, lvl;
    res_t expected_pins [$];
    int errors;
    int n_ticks;
    int n_read;
    int n_done [3];

    function new();
      gap_ticks = GAP_RESET;
      phase = PH_IDLE;
      bit_cnt = 0;
      bytes_left = 0;
      shifter = '0;
      fill = 0;
      rd_ptr = 0;
      is_read = 1'b0;
      gap_cnt = '0;
      addr_pair = '0;
      stage = 0;
      pending = OUT_OK;
      scl = 1'b1;
      drv = 1'b1;
      lvl = 1'b1;
      errors = 0;
      n_ticks = 0;
      n_read = 0;
      n_done = '{0, 0, 0};
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function void load_byte(logic [7:0] b);
      shifter = b;
      bit_cnt = 0;
      phase = PH_TX_SET;
    endfunction

    function void start_receive();
      stage = 3;
      bit_cnt = 0;
      shifter = '0;
      phase = PH_RX_REL;
    endfunction

    // decide what follows a byte once its acknowledge and gap are over
    function void after_byte();
      if (stage == 3) begin
        if (bytes_left != 0) start_receive();
        else begin
          pending = OUT_OK;
          phase = PH_END_SDA0;
        end
      end else if (shifter[0]) begin
        pending = OUT_NACK;
        phase = PH_END_SDA0;
      end else if (stage == 0) begin
        stage = 1;
        load_byte(addr_pair[7:0]);
      end else if (is_read) begin
        if (stage == 1) phase = PH_RS_SCL;
        else start_receive();
      end else if (bytes_left != 0) begin
        load_byte(payload_mem[rd_ptr % QUEUE_DEPTH]);
        rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
        bytes_left--;
        stage = 2;
      end else begin
        // a clean write skips the sda-low step before stop
        pending = OUT_OK;
        phase = PH_END_SCL;
      end
    endfunction

    function void finish_ack();
      if (gap_ticks == 0) after_byte();
      else begin
        gap_cnt = gap_ticks;
        phase = PH_GAP;
      end
    endfunction

    // advance the model by one accepted tick and queue the beat it gives
    function void apply_tick(cmd_t c);
      res_t r;
      bit rd;
      r = '0;
      n_ticks++;
      case (phase)
        PH_IDLE: begin
          if (c.func == FUNC_QUEUE) begin
            if (fill < QUEUE_DEPTH) begin
              payload_mem[fill] = c.payload_byte;
              fill++;
            end
          end else if (c.func == FUNC_WRITE || c.func == FUNC_READ) begin
            rd = (c.func == FUNC_READ);
            if ((rd && c.byte_count == 5'd0) || (!rd && int'(c.byte_count) > fill)) begin
              r.finished = 1'b1;
              r.outcome = OUT_BAD_LEN;
            end else begin
              is_read = rd;
              bytes_left = int'(c.byte_count);
              rd_ptr = 0;
              addr_pair = {c.device_addr, c.register_addr};
              stage = 0;
              drv = 1'b1;
              lvl = 1'b0;
              phase = PH_START_SCL;
            end
          end
        end
        PH_START_SDA: begin
          drv = 1'b1;
          lvl = 1'b0;
          phase = PH_START_SCL;
        end
        PH_START_SCL: begin
          scl = 1'b0;
          if (stage == 0) load_byte(addr_pair[15:8]);
          else load_byte(addr_pair[15:8] | 8'h01);
        end
        PH_TX_SET: begin
          drv = 1'b1;
          lvl = shifter[7];
          phase = PH_TX_HI;
        end
        PH_TX_HI: begin
          scl = 1'b1;
          phase = PH_TX_LO;
        end
        PH_TX_LO: begin
          scl = 1'b0;
          shifter = {shifter[6:0], 1'b0};
          bit_cnt++;
          phase = (bit_cnt >= 8) ? PH_ACK_REL : PH_TX_SET;
        end
        PH_ACK_REL: begin
          drv = 1'b0;
          phase = PH_ACK_HI;
        end
        PH_ACK_HI: begin
          scl = 1'b1;
          phase = PH_ACK_SAMPLE;
        end
        PH_ACK_SAMPLE: begin
          shifter = {7'b0, c.sda_sample};
          phase = PH_ACK_LEVEL;
        end
        PH_ACK_LEVEL: begin
          lvl = shifter[0];
          phase = PH_ACK_DRIVE;
        end
        PH_ACK_DRIVE: begin
          drv = 1'b1;
          phase = PH_ACK_LO;
        end
        PH_ACK_LO: begin
          scl = 1'b0;
          finish_ack();
        end
        PH_RS_SCL: begin
          scl = 1'b1;
          phase = PH_RS_SDA;
        end
        PH_RS_SDA: begin
          drv = 1'b1;
          lvl = 1'b1;
          stage = 2;
          phase = PH_START_SDA;
        end
        PH_RX_REL: begin
          drv = 1'b0;
          phase = PH_RX_HI;
        end
        PH_RX_HI: begin
          scl = 1'b1;
          phase = PH_RX_SAMPLE;
        end
        PH_RX_SAMPLE: begin
          shifter = {shifter[6:0], c.sda_sample};
          phase = PH_RX_LO;
        end
        PH_RX_LO: begin
          scl = 1'b0;
          bit_cnt++;
          phase = (bit_cnt >= 8) ? PH_RX_ACKLEVEL : PH_RX_HI;
        end
        PH_RX_ACKLEVEL: begin
          lvl = (bytes_left <= 1);
          phase = PH_RX_ACKDRIVE;
        end
        PH_RX_ACKDRIVE: begin
          drv = 1'b1;
          phase = PH_RX_ACKHI;
        end
        PH_RX_ACKHI: begin
          scl = 1'b1;
          phase = PH_RX_ACKLO;
        end
        PH_RX_ACKLO: begin
          scl = 1'b0;
          r.read_valid = 1'b1;
          r.read_byte = shifter;
          r.read_last = (bytes_left <= 1);
          if (bytes_left != 0) bytes_left--;
          finish_ack();
        end
        PH_GAP: begin
          if (gap_cnt != 0) gap_cnt--;
          if (gap_cnt == 0) after_byte();
        end
        PH_END_SDA0: begin
          drv = 1'b1;
          lvl = 1'b0;
          phase = PH_END_SCL;
        end
        PH_END_SCL: begin
          scl = 1'b1;
          phase = PH_END_SDA1;
        end
        default: begin
          drv = 1'b1;
          lvl = 1'b1;
          r.finished = 1'b1;
          r.outcome = pending;
          if (!is_read) begin
            fill = 0;
            rd_ptr = 0;
          end
          phase = PH_IDLE;
        end
      endcase
      r.scl_level = scl;
      r.sda_drive = drv;
      r.sda_level = drv ? lvl : 1'b0;
      r.busy_res = (phase != PH_IDLE);
      if (r.finished) n_done[r.outcome]++;
      if (r.read_valid) n_read++;
      expected_pins.push_back(r);
    endfunction

    function void diff(string name, logic [7:0] e, logic [7:0] g);
      if (g !== e) begin
        $error("%s: expected %0h, got %0h", name, e, g);
        errors++;
      end
    endfunction

    function void check_beat(res_t got);
      res_t e;
      if (expected_pins.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
        return;
      end
      e = expected_pins.pop_front();
      diff("scl_level", 8'(e.scl_level), 8'(got.scl_level));
      diff("sda_drive", 8'(e.sda_drive), 8'(got.sda_drive));
      diff("sda_level", 8'(e.sda_level), 8'(got.sda_level));
      diff("read_byte", e.read_byte, got.read_byte);
      diff("read_valid", 8'(e.read_valid), 8'(got.read_valid));
      diff("read_last", 8'(e.read_last), 8'(got.read_last));
      diff("busy_res", 8'(e.busy_res), 8'(got.busy_res));
      diff("finished", 8'(e.finished), 8'(got.finished));
      diff("outcome", 8'(e.outcome), 8'(got.outcome));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0] s_tuser = FUNC_TICK;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic m_tlast;

  // percent of cycles on which each side holds off
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mid_gap;

  i2c_pin_scoreboard sb;

  i2c_master_register_access u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #2 clk = ~clk;

  // result side: check each beat taken, then pick the next ready level
  always @(posedge clk) begin
    res_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.scl_level  = m_tdata[0];
        got.sda_drive  = m_tdata[1];
        got.sda_level  = m_tdata[2];
        got.read_byte  = m_tdata[10:3];
        got.read_valid = m_tdata[11];
        got.busy_res   = m_tdata[12];
        got.finished   = m_tdata[13];
        got.outcome    = m_tdata[15:14];
        got.read_last  = m_tlast;
        sb.check_beat(got);
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(255));
  endfunction

  // every field random; callers overwrite the ones that matter
  function automatic cmd_t rand_fields();
    cmd_t c;
    c.func = 2'($urandom_range(3));
    c.device_addr = rnd8();
    c.register_addr = rnd8();
    c.byte_count = 5'($urandom_range(16));
    c.payload_byte = rnd8();
    c.sda_sample = 1'($urandom_range(1));
    return c;
  endfunction

  // tick while a transfer runs: any command here must be ignored,
  // and the slave answers on the acknowledge sample
  function automatic cmd_t busy_tick(bit nack);
    cmd_t c;
    c = rand_fields();
    if (sb.phase == PH_ACK_SAMPLE) c.sda_sample = nack;
    return c;
  endfunction

  // present one tick beat, wait for the handshake and feed the model
  task automatic send_tick(cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= c.func;
    s_tdata <= {2'b00, c.sda_sample, c.payload_byte, c.byte_count,
                c.register_addr, c.device_addr};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    sb.apply_tick(c);
  endtask

  task automatic issue(logic [1:0] f, logic [7:0] dev, logic [7:0] regad,
                       logic [4:0] cnt, logic [7:0] pay);
    cmd_t c;
    c = rand_fields();
    c.func = f;
    c.device_addr = dev;
    c.register_addr = regad;
    c.byte_count = cnt;
    c.payload_byte = pay;
    send_tick(c);
  endtask

  // clock the running transfer to its end; the slave nacks the given
  // acknowledge (counted from zero) or none when negative
  task automatic run_to_idle(int nack_at);
    int acks;
    bit at_ack;
    acks = 0;
    while (sb.busy()) begin
      at_ack = (sb.phase == PH_ACK_SAMPLE);
      send_tick(busy_tick(acks == nack_at));
      if (at_ack) acks++;
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.expected_pins.size() != 0) @(posedge clk);
  endtask

  // register write only with the master idle and every beat back
  task automatic set_gap(logic [7:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.gap_ticks = v;
  endtask

  task automatic set_idling(int s, int r);
    send_idle_pct <= s;
    recv_idle_pct <= r;
  endtask

  // mostly well-formed traffic with random content; bad lengths, slave
  // nacks and stray ticks make up the rest
  task automatic run_random(int n_items);
    int sent;
    int pick;
    logic [4:0] cnt;
    sent = 0;
    while (sent < n_items) begin
      if (sb.busy()) send_tick(busy_tick($urandom_range(99) < 10));
      else begin
        pick = $urandom_range(99);
        if (pick < 40) issue(FUNC_QUEUE, rnd8(), rnd8(), 5'($urandom_range(16)), rnd8());
        else if (pick < 65) begin
          if ($urandom_range(9) == 0) cnt = (sb.fill < QUEUE_DEPTH) ? 5'(sb.fill + 1) : 5'd16;
          else cnt = 5'($urandom_range(sb.fill));
          issue(FUNC_WRITE, rnd8(), rnd8(), cnt, rnd8());
        end else if (pick < 90) begin
          pick = $urandom_range(99);
          if (pick < 10) cnt = 5'd0;
          else if (pick < 18) cnt = 5'($urandom_range(6, 4));
          else cnt = 5'($urandom_range(3, 1));
          issue(FUNC_READ, rnd8(), rnd8(), cnt, rnd8());
        end else issue(FUNC_TICK, rnd8(), rnd8(), 5'($urandom_range(16)), rnd8());
      end
      sent++;
    end
    run_to_idle(-1);
  endtask

  initial begin
    sb = new();
    set_idling(33, 80);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // zero-length write under the reset gap setting
    issue(FUNC_WRITE, 8'h00, 8'hFF, 5'd0, 8'h00);
    run_to_idle(-1);
    set_gap(8'd0);
    // bad lengths: empty read, write longer than the empty queue
    issue(FUNC_READ, 8'hFF, 8'h00, 5'd0, 8'hFF);
    issue(FUNC_WRITE, 8'h10, 8'h20, 5'd1, 8'h00);
    // fill the queue past its depth, the last byte is dropped
    for (int i = 0; i < QUEUE_DEPTH + 1; i++)
      issue(FUNC_QUEUE, 8'h00, 8'h00, 5'd0,
            (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : rnd8());
    issue(FUNC_WRITE, 8'h5A, 8'hC3, 5'd16, 8'h00);
    run_to_idle(-1);
    // read through the repeated start, master nacks only the final byte
    issue(FUNC_READ, 8'hA4, 8'h5A, 5'd2, 8'h00);
    run_to_idle(-1);
    // slave nack on the register byte of a write
    issue(FUNC_WRITE, 8'hC2, 8'h80, 5'd0, 8'h00);
    run_to_idle(1);

    wait_drained();
    set_idling(80, 33);
    mid_gap = $urandom_range(3, 1);
    set_gap(8'(mid_gap));
    run_random(100);

    wait_drained();
    set_idling(0, 0);
    set_gap(8'd0);
    run_random(60);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d ticks, gap settings 4, 0, %0d and 0", sb.n_ticks, mid_gap);
    $display("transfers: %0d ok, %0d nacked, %0d bad length; %0d bytes read",
             sb.n_done[OUT_OK], sb.n_done[OUT_NACK], sb.n_done[OUT_BAD_LEN], sb.n_read);
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // stuck handshake guard
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
